// ===== rtl/core/scr_pkg.sv =====
// ----------------------------------------------------------------------------
// scr_pkg
// Types and constants shared by the sphere collision and reflection pipeline.
// ----------------------------------------------------------------------------
package scr_pkg;

  localparam int VW = 24;  // vector component width
  localparam int RW = 22;  // radius width
  localparam int QB = 25;  // quotient bits produced by the divider
  localparam int DW = 47;  // divisor width (twice the squared distance)
  localparam int NW = 73;  // dividend width

  typedef struct packed {
    logic signed [VW-1:0] self_pos_x;
    logic signed [VW-1:0] self_pos_y;
    logic signed [VW-1:0] self_pos_z;
    logic        [RW-1:0] self_radius;
    logic signed [VW-1:0] other_pos_x;
    logic signed [VW-1:0] other_pos_y;
    logic signed [VW-1:0] other_pos_z;
    logic        [RW-1:0] other_radius;
    logic signed [VW-1:0] other_vel_x;
    logic signed [VW-1:0] other_vel_y;
    logic signed [VW-1:0] other_vel_z;
  } scr_in_t;

  typedef struct packed {
    logic                 hit;
    logic signed [VW-1:0] bounce_x;
    logic signed [VW-1:0] bounce_y;
    logic signed [VW-1:0] bounce_z;
    logic signed [VW-1:0] new_pos_x;
    logic signed [VW-1:0] new_pos_y;
    logic signed [VW-1:0] new_pos_z;
  } scr_out_t;

  // Per-item data that rides along the divider untouched.
  typedef struct packed {
    logic                  hit;
    logic                  dzero;
    logic [2:0]            neg;
    logic [2:0][VW-1:0]    vel;
    logic [2:0][VW-1:0]    opos;
  } scr_side_t;

  typedef struct packed {
    scr_side_t             side;
    logic [DW-1:0]         d2;
    logic [2:0][DW-1:0]    rem;
    logic [2:0][QB-1:0]    nq;
    logic [2:0]            ovf;
  } scr_div_t;

endpackage

// ===== rtl/core/scr_front.sv =====
// ----------------------------------------------------------------------------
// scr_front
// Six-stage front end: differences, products, hit test and dividend setup.
// ----------------------------------------------------------------------------
module scr_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  scr_pkg::scr_in_t in_data,
  output logic             dn_valid,
  input  logic             dn_ready,
  output scr_pkg::scr_div_t dn_data
);
  import scr_pkg::*;

  logic [6:1] vld_r;
  logic [6:1] en;

  logic [2:0][24:0] d1_r, d1_nxt;
  logic [22:0]      rng1_r, rng1_nxt;
  logic [2:0][23:0] vel1_r, vel1_nxt, op1_r, op1_nxt;

  logic [2:0][48:0] prod2_r, prod2_nxt, sq2_r, sq2_nxt;
  logic [45:0]      rsq2_r, rsq2_nxt;
  logic [2:0][22:0] dmag2_r, dmag2_nxt;
  logic [2:0]       dneg2_r, dneg2_nxt;
  logic [2:0][23:0] vel2_r, op2_r;

  logic signed [50:0] vd3_r, vd3_nxt;
  logic [50:0]        dist3_r, dist3_nxt;
  logic               hit3_r, hit3_nxt;
  logic [2:0][22:0]   dmag3_r;
  logic [2:0]         dneg3_r;
  logic [2:0][23:0]   vel3_r, op3_r;

  logic [2:0][46:0] ph4_r, ph4_nxt, pl4_r, pl4_nxt;
  logic [45:0]      d4_r;
  scr_side_t        side4_r, side4_nxt;

  logic [2:0][NW-1:0] n5_r, n5_nxt;
  logic [DW-1:0]      d5_r;
  scr_side_t          side5_r;

  scr_div_t dn_r, dn_nxt;

  always_comb begin
    en[6] = !vld_r[6] || dn_ready;
    for (int k = 5; k >= 1; k--) en[k] = !vld_r[k] || en[k+1];
  end
  assign in_ready = en[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[1]) vld_r[1] <= in_valid;
      for (int k = 2; k <= 6; k++) begin
        if (en[k]) vld_r[k] <= vld_r[k-1];
      end
    end
  end

  // Stage 1: center difference and radius sum.
  always_comb begin
    logic [2:0][23:0] sp;
    sp[0] = in_data.self_pos_x;
    sp[1] = in_data.self_pos_y;
    sp[2] = in_data.self_pos_z;
    op1_nxt[0] = in_data.other_pos_x;
    op1_nxt[1] = in_data.other_pos_y;
    op1_nxt[2] = in_data.other_pos_z;
    vel1_nxt[0] = in_data.other_vel_x;
    vel1_nxt[1] = in_data.other_vel_y;
    vel1_nxt[2] = in_data.other_vel_z;
    for (int i = 0; i < 3; i++) begin
      d1_nxt[i] = {sp[i][23], sp[i]} - {op1_nxt[i][23], op1_nxt[i]};
    end
    rng1_nxt = {1'b0, in_data.self_radius} + {1'b0, in_data.other_radius};
  end

  // Stage 2: v.d terms, squared distances and squared radius sum.
  always_comb begin
    logic signed [48:0] vs, ds;
    logic [24:0] dm;
    for (int i = 0; i < 3; i++) begin
      vs = 49'($signed(vel1_r[i]));
      ds = 49'($signed(d1_r[i]));
      prod2_nxt[i] = vs * ds;
      sq2_nxt[i]   = ds * ds;
      dneg2_nxt[i] = d1_r[i][24];
      dm = d1_r[i][24] ? (25'd0 - d1_r[i]) : d1_r[i];
      dmag2_nxt[i] = dm[22:0];
    end
    rsq2_nxt = 46'(rng1_r) * 46'(rng1_r);
  end

  // Stage 3: dot product, squared distance and the hit decision.
  always_comb begin
    vd3_nxt = 51'($signed(prod2_r[0])) + 51'($signed(prod2_r[1]))
            + 51'($signed(prod2_r[2]));
    dist3_nxt = 51'(sq2_r[0]) + 51'(sq2_r[1]) + 51'(sq2_r[2]);
    hit3_nxt = 51'(rsq2_r) > dist3_nxt;
  end

  // Stage 4: 2|v.d| times |d_i|, split into two partial products.
  always_comb begin
    logic [50:0] amag;
    logic [47:0] a;
    amag = vd3_r[50] ? (51'd0 - vd3_r) : vd3_r;
    a = {amag[46:0], 1'b0};
    for (int i = 0; i < 3; i++) begin
      ph4_nxt[i] = 47'(a[47:24]) * 47'(dmag3_r[i]);
      pl4_nxt[i] = 47'(a[23:0]) * 47'(dmag3_r[i]);
      side4_nxt.neg[i] = vd3_r[50] ^ dneg3_r[i];
    end
    side4_nxt.hit   = hit3_r;
    side4_nxt.dzero = (dist3_r == '0);
    side4_nxt.vel   = vel3_r;
    side4_nxt.opos  = op3_r;
  end

  // Stage 5: dividend 2N + D, so the floor quotient by 2D rounds half away.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      n5_nxt[i] = (NW'(ph4_r[i]) << 25) + (NW'(pl4_r[i]) << 1) + NW'(d4_r);
    end
  end

  // Stage 6: leading remainder and the quotient overflow check.
  always_comb begin
    dn_nxt.side = side5_r;
    dn_nxt.d2   = d5_r;
    for (int i = 0; i < 3; i++) begin
      dn_nxt.rem[i] = n5_r[i][NW-2:QB];
      dn_nxt.nq[i]  = n5_r[i][QB-1:0];
      dn_nxt.ovf[i] = n5_r[i][NW-1:QB] >= {1'b0, d5_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      d1_r <= d1_nxt;
      rng1_r <= rng1_nxt;
      vel1_r <= vel1_nxt;
      op1_r <= op1_nxt;
    end
    if (en[2]) begin
      prod2_r <= prod2_nxt;
      sq2_r <= sq2_nxt;
      rsq2_r <= rsq2_nxt;
      dmag2_r <= dmag2_nxt;
      dneg2_r <= dneg2_nxt;
      vel2_r <= vel1_r;
      op2_r <= op1_r;
    end
    if (en[3]) begin
      vd3_r <= vd3_nxt;
      dist3_r <= dist3_nxt;
      hit3_r <= hit3_nxt;
      dmag3_r <= dmag2_r;
      dneg3_r <= dneg2_r;
      vel3_r <= vel2_r;
      op3_r <= op2_r;
    end
    if (en[4]) begin
      ph4_r <= ph4_nxt;
      pl4_r <= pl4_nxt;
      d4_r <= dist3_r[45:0];
      side4_r <= side4_nxt;
    end
    if (en[5]) begin
      n5_r <= n5_nxt;
      d5_r <= {d4_r, 1'b0};
      side5_r <= side4_r;
    end
    if (en[6]) begin
      dn_r <= dn_nxt;
    end
  end

  assign dn_valid = vld_r[6];
  assign dn_data  = dn_r;

endmodule

// ===== rtl/core/scr_div_stage.sv =====
// ----------------------------------------------------------------------------
// scr_div_stage
// One restoring division step on all three lanes, one quotient bit each.
// ----------------------------------------------------------------------------
module scr_div_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  scr_pkg::scr_div_t up_data,
  output logic              dn_valid,
  input  logic              dn_ready,
  output scr_pkg::scr_div_t dn_data
);
  import scr_pkg::*;

  logic     vld_r;
  scr_div_t data_r, data_nxt;
  logic     en;

  assign en = !vld_r || dn_ready;
  assign up_ready = en;

  always_comb begin
    logic [DW:0] t, diff;
    logic        ge;
    data_nxt = up_data;
    for (int i = 0; i < 3; i++) begin
      t    = {up_data.rem[i], up_data.nq[i][QB-1]};
      diff = t - {1'b0, up_data.d2};
      ge   = t >= {1'b0, up_data.d2};
      data_nxt.rem[i] = ge ? diff[DW-1:0] : t[DW-1:0];
      data_nxt.nq[i]  = {up_data.nq[i][QB-2:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) data_r <= data_nxt;
  end

  assign dn_valid = vld_r;
  assign dn_data  = data_r;

  // Without overflow the partial remainder always stays below the divisor.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r && !data_r.ovf[0] && data_r.d2 != '0 |-> data_r.rem[0] < data_r.d2)
    else $error("division remainder out of range");

endmodule

// ===== rtl/core/scr_back.sv =====
// ----------------------------------------------------------------------------
// scr_back
// Reflection, saturation, new position and the output register.
// ----------------------------------------------------------------------------
module scr_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              up_valid,
  output logic              up_ready,
  input  scr_pkg::scr_div_t up_data,
  output logic              out_valid,
  input  logic              out_ready,
  output scr_pkg::scr_out_t out_data
);
  import scr_pkg::*;

  logic     out_valid_r;
  scr_out_t out_r, out_nxt;
  logic     en;

  assign en = !out_valid_r || out_ready;
  assign up_ready = en;

  always_comb begin
    logic [2:0][23:0] b, np;
    logic [25:0]        cmag;
    logic signed [26:0] cs, bw;
    logic signed [24:0] pw;
    for (int i = 0; i < 3; i++) begin
      // An overflowed quotient only needs to be large enough to saturate.
      if (up_data.side.dzero) cmag = '0;
      else if (up_data.ovf[i]) cmag = 26'h2000000;
      else cmag = {1'b0, up_data.nq[i]};
      cs = up_data.side.neg[i] ? -$signed({1'b0, cmag}) : $signed({1'b0, cmag});
      bw = 27'($signed(up_data.side.vel[i])) - cs;
      if (bw > 27'sd8388607) b[i] = 24'h7FFFFF;
      else if (bw < -27'sd8388608) b[i] = 24'h800000;
      else b[i] = bw[23:0];
      pw = 25'($signed(up_data.side.opos[i])) + 25'($signed(b[i]));
      if (pw > 25'sd8388607) np[i] = 24'h7FFFFF;
      else if (pw < -25'sd8388608) np[i] = 24'h800000;
      else np[i] = pw[23:0];
      if (!up_data.side.hit) begin
        b[i]  = '0;
        np[i] = '0;
      end
    end
    out_nxt.hit       = up_data.side.hit;
    out_nxt.bounce_x  = b[0];
    out_nxt.bounce_y  = b[1];
    out_nxt.bounce_z  = b[2];
    out_nxt.new_pos_x = np[0];
    out_nxt.new_pos_y = np[1];
    out_nxt.new_pos_z = np[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.hit |-> out_r.bounce_x == '0 && out_r.bounce_y == '0
      && out_r.bounce_z == '0 && out_r.new_pos_x == '0 && out_r.new_pos_y == '0
      && out_r.new_pos_z == '0)
    else $error("miss item carries nonzero vectors");

  a_coincident: assert property (@(posedge clk) disable iff (!rst_n)
    en && up_valid && up_data.side.hit && up_data.side.dzero
      |=> out_r.bounce_x == $past(up_data.side.vel[0]))
    else $error("coincident centers must pass the velocity through");

endmodule

// ===== rtl/core/sphere_collide_reflect_top.sv =====
// ----------------------------------------------------------------------------
// sphere_collide_reflect_top
// Sphere pair hit test with velocity reflection about the center normal.
// ----------------------------------------------------------------------------
//  Channel | Handshake              | Payload
//  input   | in_valid / in_ready    | in_data  (scr_in_t)
//  result  | out_valid / out_ready  | out_data (scr_out_t)
//
//  One item per cycle while out_ready holds; the path is 6 front stages, 25 divider
//  stages and one output register, the divider producing one quotient bit per stage.
//  Reset clears every stage valid bit; payload registers are not reset.
//  Each stage holds while the next one is full and stalled, so bubbles
//  close up and a stall loses and repeats nothing.
// ----------------------------------------------------------------------------
module sphere_collide_reflect_top (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  scr_pkg::scr_in_t in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output scr_pkg::scr_out_t out_data
);
  import scr_pkg::*;

  logic     st_valid [QB+1];
  logic     st_ready [QB+1];
  scr_div_t st_data  [QB+1];

  scr_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .dn_valid (st_valid[0]),
    .dn_ready (st_ready[0]),
    .dn_data  (st_data[0])
  );

  for (genvar g = 0; g < QB; g++) begin : g_div
    scr_div_stage u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (st_valid[g]),
      .up_ready (st_ready[g]),
      .up_data  (st_data[g]),
      .dn_valid (st_valid[g+1]),
      .dn_ready (st_ready[g+1]),
      .dn_data  (st_data[g+1])
    );
  end

  scr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (st_valid[QB]),
    .up_ready  (st_ready[QB]),
    .up_data   (st_data[QB]),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
